>>> hw/rtl/distance_vector_route_table_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the route table
// Immediate-free concurrent assertion wrappers, empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef DISTANCE_VECTOR_ROUTE_TABLE_ASSERT_SVH
`define DISTANCE_VECTOR_ROUTE_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
`define DVRT_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define DVRT_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define DVRT_ASSERT(lbl, clk, rstn, prop, msg)
`define DVRT_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

>>> hw/rtl/dvrt_pkg.sv
// ----------------------------------------------------------------------------
// dvrt_pkg
// Shared types and codes of the route table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package dvrt_pkg;
  localparam logic [1:0] FUNC_INSTALL = 2'd0;
  localparam logic [1:0] FUNC_ADVERT  = 2'd1;
  localparam logic [1:0] FUNC_TICK    = 2'd2;
  localparam logic [1:0] FUNC_SPARE   = 2'd3;  // unused code, answered ignored

  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_REPLACED  = 3'd1;
  localparam logic [2:0] ST_REFRESHED = 3'd2;
  localparam logic [2:0] ST_IGNORED   = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;

  localparam logic [2:0] REG_COST0 = 3'd0;
  localparam logic [2:0] REG_COST1 = 3'd1;
  localparam logic [2:0] REG_COST2 = 3'd2;
  localparam logic [2:0] REG_COST3 = 3'd3;
  localparam logic [2:0] REG_STALE = 3'd4;

  localparam logic [31:0] UNREACH = 32'hFFFF_FFFF;
  localparam logic [2:0]  AGE_MAX = 3'd7;

  // classified item passed from front to back
  typedef struct packed {
    logic        tick;    // table walk and dump
    logic        ignore;  // answer ignored at once
    logic        install;
    logic [31:0] addr;
    logic [5:0]  pfx;
    logic [31:0] metric;  // cost for install, summed distance for advert
    logic [31:0] sender;
  } cmd_t;
endpackage

>>> hw/rtl/dvrt_front.sv
// ----------------------------------------------------------------------------
// dvrt_front
// Accepts input beats, adds link cost with saturation, queues commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module dvrt_front import dvrt_pkg::*; #(
  parameter int NUM_IFACES = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic [1:0]  iface_i,
  input  logic [31:0] addr_i,
  input  logic [5:0]  pfx_i,
  input  logic [31:0] adv_i,
  input  logic [31:0] sender_i,
  input  logic [31:0] cost0_i,
  input  logic [31:0] cost1_i,
  input  logic [31:0] cost2_i,
  input  logic [31:0] cost3_i,
  output logic        cmd_valid_o,
  input  logic        cmd_ready_i,
  output cmd_t        cmd_o
);
  // two-entry queue
  cmd_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  cmd_t       c;
  logic [31:0] cost;
  logic [32:0] sum;
  logic       push, pop;

  always_comb begin
    case (iface_i)
      2'd0:    cost = cost0_i;
      2'd1:    cost = cost1_i;
      2'd2:    cost = cost2_i;
      default: cost = cost3_i;
    endcase
    sum = {1'b0, adv_i} + {1'b0, cost};
    c = '0;
    c.addr = addr_i;
    c.pfx = pfx_i;
    c.sender = sender_i;
    c.install = (func_i == FUNC_INSTALL);
    c.tick = (func_i == FUNC_TICK);
    c.ignore = (func_i == FUNC_SPARE) ||
               ((func_i != FUNC_TICK) && ({30'd0, iface_i} >= NUM_IFACES));
    if (func_i == FUNC_INSTALL) c.metric = cost;
    else if (adv_i == UNREACH || sum >= {1'b0, UNREACH}) c.metric = UNREACH;
    else c.metric = sum[31:0];
  end

  assign in_ready_o  = (cnt_q != 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = mem_q[rp_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = cmd_valid_o && cmd_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  `include "distance_vector_route_table_assert.svh"
  `DVRT_ASSERT(a_cnt_range, clk_i, rst_ni, cnt_q != 2'd3, "queue count out of range")
  `DVRT_ASSERT(a_no_pop_empty, clk_i, rst_ni, pop |-> cnt_q != 2'd0, "pop of empty queue")
  `DVRT_ASSERT(a_push_cnt, clk_i, rst_ni, (push && !pop) |=> cnt_q == $past(cnt_q) + 2'd1, "no rise")
endmodule

>>> hw/rtl/dvrt_back.sv
// ----------------------------------------------------------------------------
// dvrt_back
// Holds the table, runs lookups, updates and the tick walk, emits results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module dvrt_back import dvrt_pkg::*; #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cmd_valid_i,
  output logic         cmd_ready_o,
  input  cmd_t         cmd_i,
  input  logic [2:0]   stale_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output logic [106:0] out_data_o,
  output logic         out_kind_o,
  output logic         out_last_o
);
  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  typedef enum logic [1:0] {S_IDLE, S_AGE, S_DUMP, S_OUT} state_e;
  state_e state_q;

  logic [TABLE_DEPTH-1:0] vld_q;
  logic [31:0] addr_q [TABLE_DEPTH];
  logic [5:0]  pfx_q  [TABLE_DEPTH];
  logic [31:0] dist_q [TABLE_DEPTH];
  logic [31:0] via_q  [TABLE_DEPTH];
  logic        dir_q  [TABLE_DEPTH];
  logic [2:0]  age_q  [TABLE_DEPTH];

  logic [IW-1:0] idx_q;
  logic          any_q;
  logic          ov_q, olast_q, okind_q;
  logic [106:0]  odata_q;

  // parallel key match and first free search
  logic          hit, free;
  logic [IW-1:0] hidx, fidx;
  always_comb begin
    hit = 1'b0; free = 1'b0; hidx = '0; fidx = '0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (vld_q[i] && addr_q[i] == cmd_i.addr && pfx_q[i] == cmd_i.pfx) begin
        hit = 1'b1; hidx = IW'(i);
      end
      if (!vld_q[i]) begin
        free = 1'b1; fidx = IW'(i);
      end
    end
  end

  logic busy_out;
  assign busy_out = ov_q && !out_ready_i;
  assign cmd_ready_o = (state_q == S_IDLE) && !busy_out;
  assign out_valid_o = ov_q;
  assign out_data_o  = odata_q;
  assign out_kind_o  = okind_q;
  assign out_last_o  = olast_q;

  // a new beat is loaded this cycle
  logic ov_set;
  always_comb begin
    case (state_q)
      S_IDLE:  ov_set = cmd_valid_i && cmd_ready_o && !cmd_i.tick;
      S_DUMP:  ov_set = !busy_out && vld_q[idx_q];
      S_OUT:   ov_set = !busy_out && !any_q;
      default: ov_set = 1'b0;
    endcase
  end

  // dump data: {via, direct, distance, prefix, addr, valid, status}
  function automatic logic [106:0] pack_st(logic [2:0] st);
    return {104'd0, st};
  endfunction

  logic [IW-1:0] last_idx;
  assign last_idx = IW'(TABLE_DEPTH - 1);

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && cmd_valid_i && cmd_ready_o && !cmd_i.tick &&
        !cmd_i.ignore) begin
      if (cmd_i.install && (hit || free)) begin
        addr_q[hit ? hidx : fidx] <= cmd_i.addr;
        pfx_q[hit ? hidx : fidx]  <= cmd_i.pfx;
        dist_q[hit ? hidx : fidx] <= cmd_i.metric;
        via_q[hit ? hidx : fidx]  <= cmd_i.addr;
        dir_q[hit ? hidx : fidx]  <= 1'b1;
        age_q[hit ? hidx : fidx]  <= '0;
      end else if (!cmd_i.install && ((!hit && free) ||
                   (hit && cmd_i.metric < dist_q[hidx]))) begin
        addr_q[hit ? hidx : fidx] <= cmd_i.addr;
        pfx_q[hit ? hidx : fidx]  <= cmd_i.pfx;
        dist_q[hit ? hidx : fidx] <= cmd_i.metric;
        via_q[hit ? hidx : fidx]  <= cmd_i.sender;
        dir_q[hit ? hidx : fidx]  <= 1'b0;
        age_q[hit ? hidx : fidx]  <= '0;
      end else if (!cmd_i.install && hit && via_q[hidx] == cmd_i.sender) begin
        dist_q[hidx] <= cmd_i.metric;
        age_q[hidx]  <= '0;
      end
    end
    if (state_q == S_AGE && vld_q[idx_q] && !dir_q[idx_q]) begin
      if (age_q[idx_q] < AGE_MAX) begin
        age_q[idx_q] <= age_q[idx_q] + 3'd1;
        if (age_q[idx_q] + 3'd1 > stale_i) dist_q[idx_q] <= UNREACH;
      end else if (age_q[idx_q] > stale_i) dist_q[idx_q] <= UNREACH;
    end
  end

  logic rest;
  always_comb begin
    rest = 1'b0;
    for (int i = 0; i < TABLE_DEPTH; i++)
      if (IW'(i) > idx_q && vld_q[i]) rest = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; vld_q <= '0; idx_q <= '0; any_q <= 1'b0;
      ov_q <= 1'b0; olast_q <= 1'b0; okind_q <= 1'b0; odata_q <= '0;
    end else begin
      if (ov_set) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (cmd_valid_i && cmd_ready_o) begin
            if (cmd_i.tick) begin
              state_q <= S_AGE; idx_q <= '0;
            end else begin
              okind_q <= 1'b0; olast_q <= 1'b1;
              if (cmd_i.ignore) odata_q <= pack_st(ST_IGNORED);
              else if (cmd_i.install) begin
                if (hit) odata_q <= pack_st(ST_REPLACED);
                else if (free) begin
                  odata_q <= pack_st(ST_INSERTED); vld_q[fidx] <= 1'b1;
                end else odata_q <= pack_st(ST_FULL);
              end else if (!hit) begin
                if (free) begin
                  odata_q <= pack_st(ST_INSERTED); vld_q[fidx] <= 1'b1;
                end else odata_q <= pack_st(ST_FULL);
              end else if (cmd_i.metric < dist_q[hidx]) odata_q <= pack_st(ST_REPLACED);
              else if (via_q[hidx] == cmd_i.sender) odata_q <= pack_st(ST_REFRESHED);
              else odata_q <= pack_st(ST_IGNORED);
            end
          end
        end
        S_AGE: begin
          if (idx_q == last_idx) begin
            state_q <= S_DUMP; idx_q <= '0; any_q <= 1'b0;
          end else idx_q <= idx_q + 1'b1;
        end
        S_DUMP: begin
          if (!busy_out) begin
            if (vld_q[idx_q]) begin
              okind_q <= 1'b1; olast_q <= !rest; any_q <= 1'b1;
              odata_q <= {via_q[idx_q], dir_q[idx_q], dist_q[idx_q], pfx_q[idx_q],
                          addr_q[idx_q], 1'b1, ST_INSERTED};
            end
            if (idx_q == last_idx) state_q <= S_OUT;
            else idx_q <= idx_q + 1'b1;
          end
        end
        S_OUT: begin
          if (!busy_out) begin
            if (!any_q) begin
              okind_q <= 1'b1; olast_q <= 1'b1; odata_q <= '0;
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `include "distance_vector_route_table_assert.svh"
  `DVRT_ASSERT(a_kind_st, clk_i, rst_ni, (ov_q && !okind_q) |-> olast_q, "status beat without last")
  `DVRT_ASSERT(a_no_take_busy, clk_i, rst_ni, (state_q != S_IDLE) |-> !cmd_ready_o, "command taken while busy")
  `DVRT_ASSERT(a_hold, clk_i, rst_ni, (ov_q && !out_ready_i) |=> ov_q && $stable(odata_q), "result dropped")
endmodule

>>> hw/rtl/distance_vector_route_table.sv
// ----------------------------------------------------------------------------
// distance_vector_route_table
// Distance-vector route table with install, advertisement and round tick.
// ----------------------------------------------------------------------------
// Channel   Dir  Beat contents
// s_axis    in   one command: install, advertisement or tick
// m_axis    out  one status beat, or one dump beat per valid slot (one empty beat if none)
// cfg       in   write of a link cost or the stale limit
//
// Install/advertisement: the command is registered in the front queue, then
// looked up and updated in the back end, which registers the status beat.
// A tick walks every slot to age it, then walks again to dump, pausing on
// output stalls, and ends in a closing state that sends an empty beat when
// no slot was valid.
// Reset clears the valid bits at once; there is no clearing pass.
// The front queue (two commands) keeps accepting while the back end walks, until it is full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module distance_vector_route_table import dvrt_pkg::*; #(
  parameter int TABLE_DEPTH = 16,
  parameter int NUM_IFACES  = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // func[1:0], iface_index[3:2], net_addr[35:4], prefix[41:36],
  // adv_distance[73:42], sender_addr[105:74]
  input  logic [111:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status[2:0], entry_valid[3], entry_addr[35:4], entry_prefix[41:36],
  // entry_distance[73:42], entry_direct[74], entry_via[106:75]
  output logic [111:0] m_axis_tdata,
  // result_kind[0]
  output logic         m_axis_tuser,
  output logic         m_axis_tlast,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [31:0]  cfg_data_i
);
  logic [31:0] cost_q [4];
  logic [2:0]  stale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) cost_q[i] <= 32'd1;
      stale_q <= 3'd3;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_COST0: cost_q[0] <= cfg_data_i;
        REG_COST1: cost_q[1] <= cfg_data_i;
        REG_COST2: cost_q[2] <= cfg_data_i;
        REG_COST3: cost_q[3] <= cfg_data_i;
        REG_STALE: stale_q <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  cmd_t         cmd;
  logic         cmd_valid, cmd_ready;
  logic [106:0] odata;

  dvrt_front #(.NUM_IFACES(NUM_IFACES)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .func_i(s_axis_tdata[1:0]), .iface_i(s_axis_tdata[3:2]),
    .addr_i(s_axis_tdata[35:4]), .pfx_i(s_axis_tdata[41:36]),
    .adv_i(s_axis_tdata[73:42]), .sender_i(s_axis_tdata[105:74]),
    .cost0_i(cost_q[0]), .cost1_i(cost_q[1]), .cost2_i(cost_q[2]),
    .cost3_i(cost_q[3]),
    .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready), .cmd_o(cmd)
  );

  dvrt_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready), .cmd_i(cmd),
    .stale_i(stale_q),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .out_data_o(odata), .out_kind_o(m_axis_tuser), .out_last_o(m_axis_tlast)
  );

  // odata order from bit 0: status, valid, addr, prefix, distance, direct, via
  assign m_axis_tdata = {5'd0, odata};
endmodule

>>> verif/distance_vector_route_table_tb.sv
// ----------------------------------------------------------------------------
// distance_vector_route_table_tb
// Self-checking bench for the route table. A directed table covers installs,
// refreshes, replacements, saturation, stale ageing and the full table. A
// random part follows over several cost and stale settings. Every output
// beat is compared with a predictor that keeps its own copy of the table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module distance_vector_route_table_tb;
  import dvrt_pkg::*;

  localparam int DEPTH      = 16;
  localparam int CYCLE_CAP  = 400000;
  localparam int KEY_POOL   = 20;
  localparam int PEER_POOL  = 6;

  // one output beat as the predictor sees it
  typedef struct packed {
    logic        kind;
    logic [2:0]  status;
    logic        valid;
    logic [31:0] addr;
    logic [5:0]  pfx;
    logic [31:0] metric;
    logic        direct;
    logic [31:0] via;
    logic        last;
  } route_beat_t;

  // directed row; chk set where the status is typed in by hand
  typedef struct packed {
    logic [1:0]  func;
    logic [1:0]  ifc;
    logic [31:0] addr;
    logic [5:0]  pfx;
    logic [31:0] adv;
    logic [31:0] sender;
    logic        chk;
    logic [2:0]  want;
  } route_cmd_t;

  localparam int NROWS = 16;
  route_cmd_t dir_rows [NROWS] = '{
    '{FUNC_TICK,    2'd0, 32'h0,          6'd0,  32'h0,          32'h0,          1'b0, ST_INSERTED},
    '{FUNC_INSTALL, 2'd0, 32'h0A00_0000,  6'd24, 32'h0,          32'h0,          1'b1, ST_INSERTED},
    '{FUNC_INSTALL, 2'd0, 32'h0A00_0000,  6'd24, 32'h0,          32'h0,          1'b1, ST_REPLACED},
    '{FUNC_INSTALL, 2'd3, 32'hFFFF_FFFF,  6'd32, 32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b1, ST_INSERTED},
    '{FUNC_INSTALL, 2'd1, 32'h0,          6'd0,  32'h0,          32'h0,          1'b1, ST_INSERTED},
    '{FUNC_ADVERT,  2'd0, 32'h0A00_0000,  6'd24, 32'h0,          32'h0A00_0000,  1'b1, ST_REFRESHED},
    '{FUNC_ADVERT,  2'd2, 32'hC0A8_0000,  6'd16, 32'd5,          32'h1111_1111,  1'b1, ST_INSERTED},
    '{FUNC_ADVERT,  2'd2, 32'hC0A8_0000,  6'd16, 32'd2,          32'h2222_2222,  1'b1, ST_REPLACED},
    '{FUNC_ADVERT,  2'd1, 32'hC0A8_0000,  6'd16, 32'd9,          32'h3333_3333,  1'b1, ST_IGNORED},
    '{FUNC_ADVERT,  2'd1, 32'hC0A8_0000,  6'd16, 32'd9,          32'h2222_2222,  1'b1, ST_REFRESHED},
    '{FUNC_ADVERT,  2'd3, 32'h5555_AAAA,  6'd8,  32'hFFFF_FFFF,  32'hAAAA_AAAA,  1'b0, ST_INSERTED},
    '{FUNC_ADVERT,  2'd0, 32'hAAAA_5555,  6'd31, 32'hFFFF_FFFE,  32'h5555_5555,  1'b0, ST_INSERTED},
    '{FUNC_SPARE,   2'd3, 32'hFFFF_FFFF,  6'd63, 32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b1, ST_IGNORED},
    '{FUNC_TICK,    2'd3, 32'hFFFF_FFFF,  6'd63, 32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b0, ST_INSERTED},
    '{FUNC_TICK,    2'd0, 32'h0,          6'd0,  32'h0,          32'h0,          1'b0, ST_INSERTED},
    '{FUNC_TICK,    2'd1, 32'h0,          6'd0,  32'h0,          32'h0,          1'b0, ST_INSERTED}
  };

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [111:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [111:0] m_axis_tdata;
  logic         m_axis_tuser;
  logic         m_axis_tlast;
  logic         cfg_we_i = 1'b0;
  logic [2:0]   cfg_idx_i = '0;
  logic [31:0]  cfg_data_i = '0;

  distance_vector_route_table u_top (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // predictor's copy of registers and table
  logic [31:0] link_cost [4];
  logic [2:0]  stale_lim;
  logic        rt_valid  [DEPTH];
  logic [31:0] rt_addr   [DEPTH];
  logic [5:0]  rt_pfx    [DEPTH];
  logic [31:0] rt_dist   [DEPTH];
  logic [31:0] rt_via    [DEPTH];
  logic        rt_direct [DEPTH];
  logic [2:0]  rt_age    [DEPTH];

  route_beat_t pending_beats [$];
  int          fail_count = 0;
  int          cycle_count = 0;
  bit          quiet = 1'b0;  // no idling on either side while set

  logic [31:0] key_addr [KEY_POOL];
  logic [5:0]  key_pfx  [KEY_POOL];
  logic [31:0] peer     [PEER_POOL];

  task automatic report(input string what, input route_beat_t got, input route_beat_t exp);
    $display("mismatch %s: got %h exp %h", what, got, exp);
    fail_count++;
  endtask

  task automatic push_status(input logic [2:0] code);
    route_beat_t b;
    b = '0;
    b.status = code;
    b.last = 1'b1;
    pending_beats = {pending_beats, b};
  endtask

  // next-state and expected beats of one accepted command
  task automatic route_update(input route_cmd_t c);
    int hit;
    int slot;
    int n;
    logic [32:0] sum;
    logic [31:0] nd;
    route_beat_t b;
    hit = -1;
    slot = -1;
    n = 0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (rt_valid[i] && rt_addr[i] == c.addr && rt_pfx[i] == c.pfx) hit = i;
      if (!rt_valid[i]) slot = i;
    end
    if (c.func == FUNC_INSTALL || c.func == FUNC_ADVERT) begin
      if (c.func == FUNC_INSTALL) nd = link_cost[c.ifc];
      else if (c.adv == UNREACH) nd = UNREACH;
      else begin
        sum = {1'b0, c.adv} + {1'b0, link_cost[c.ifc]};
        nd = (sum >= {1'b0, UNREACH}) ? UNREACH : sum[31:0];
      end
      if (hit < 0 && slot < 0) push_status(ST_FULL);
      else if (c.func == FUNC_INSTALL || hit < 0 || nd < rt_dist[hit]) begin
        if (hit >= 0) push_status(ST_REPLACED);
        else begin
          push_status(ST_INSERTED);
          hit = slot;
        end
        rt_valid[hit]  = 1'b1;
        rt_addr[hit]   = c.addr;
        rt_pfx[hit]    = c.pfx;
        rt_dist[hit]   = nd;
        rt_via[hit]    = (c.func == FUNC_INSTALL) ? c.addr : c.sender;
        rt_direct[hit] = (c.func == FUNC_INSTALL);
        rt_age[hit]    = '0;
      end else if (rt_via[hit] == c.sender) begin
        rt_dist[hit] = nd;
        rt_age[hit]  = '0;
        push_status(ST_REFRESHED);
      end else push_status(ST_IGNORED);
    end else if (c.func == FUNC_TICK) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (rt_valid[i] && !rt_direct[i]) begin
          if (rt_age[i] < AGE_MAX) rt_age[i]++;
          if (rt_age[i] > stale_lim) rt_dist[i] = UNREACH;
        end
      end
      for (int i = 0; i < DEPTH; i++) begin
        if (rt_valid[i]) begin
          b = '0;
          b.kind   = 1'b1;
          b.valid  = 1'b1;
          b.addr   = rt_addr[i];
          b.pfx    = rt_pfx[i];
          b.metric = rt_dist[i];
          b.direct = rt_direct[i];
          b.via    = rt_via[i];
          pending_beats = {pending_beats, b};
          n++;
        end
      end
      if (n == 0) begin
        b = '0;
        b.kind = 1'b1;
        pending_beats = {pending_beats, b};
      end
      pending_beats[$].last = 1'b1;
    end else push_status(ST_IGNORED);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // one beat on the input side; the predictor runs at acceptance
  task automatic send_cmd(input route_cmd_t c);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, c.sender, c.adv, c.pfx, c.addr, c.ifc, c.func};
    do @(posedge clk_i); while (!s_axis_tready);
    route_update(c);
    if (c.chk) pending_beats[$].status = c.want;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [31:0] c0, c1, c2, c3, input logic [2:0] stale);
    logic [31:0] vals [5];
    vals = '{c0, c1, c2, c3, {29'd0, stale}};
    for (int i = 0; i < 5; i++) begin
      @(posedge clk_i);
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= 3'(i);
      cfg_data_i <= vals[i];
      if (i < 4) link_cost[i] = vals[i];
      else stale_lim = stale;
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic route_cmd_t random_cmd();
    route_cmd_t c;
    int r;
    int k;
    c = '0;
    r = $urandom_range(0, 99);
    k = $urandom_range(0, KEY_POOL - 1);
    c.ifc    = 2'($urandom_range(0, 3));
    c.addr   = key_addr[k];
    c.pfx    = key_pfx[k];
    c.sender = peer[$urandom_range(0, PEER_POOL - 1)];
    case ($urandom_range(0, 7))
      0:       c.adv = UNREACH;
      1:       c.adv = $urandom;
      default: c.adv = $urandom_range(0, 40);
    endcase
    if ($urandom_range(0, 5) == 0) c.sender = c.addr;  // refresh of a direct route
    if (r < 22) c.func = FUNC_INSTALL;
    else if (r < 78) c.func = FUNC_ADVERT;
    else if (r < 94) c.func = FUNC_TICK;
    else begin
      // noise: spare code with everything random
      c.func   = FUNC_SPARE;
      c.addr   = $urandom;
      c.pfx    = 6'($urandom);
      c.adv    = $urandom;
      c.sender = $urandom;
    end
    return c;
  endfunction

  // output side: compare every beat, stall tready at random
  int stall_left = 0;
  always @(posedge clk_i) begin
    route_beat_t got;
    route_beat_t exp;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tuser, m_axis_tdata[2:0], m_axis_tdata[3], m_axis_tdata[35:4],
             m_axis_tdata[41:36], m_axis_tdata[73:42], m_axis_tdata[74],
             m_axis_tdata[106:75], m_axis_tlast};
      if (pending_beats.size() == 0) report("unexpected beat", got, '0);
      else begin
        exp = pending_beats.pop_front();
        if (got !== exp) report("beat fields", got, exp);
      end
    end
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      stall_left <= pick_gap();
      m_axis_tready <= rst_ni;
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    route_cmd_t c;
    for (int i = 0; i < 4; i++) link_cost[i] = 32'd1;
    stale_lim = 3'd3;
    for (int i = 0; i < DEPTH; i++) rt_valid[i] = 1'b0;
    for (int i = 0; i < KEY_POOL; i++) begin
      key_addr[i] = $urandom;
      key_pfx[i]  = 6'($urandom_range(0, 32));
    end
    key_pfx[0] = 6'd32;
    for (int i = 0; i < PEER_POOL; i++) peer[i] = $urandom;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part at reset settings
    for (int i = 0; i < NROWS; i++) send_cmd(dir_rows[i]);
    // fill the table to its last slot, then one key too many
    for (int i = 0; i < 11; i++) begin
      c = '0;
      c.func = FUNC_INSTALL;
      c.ifc  = 2'(i);
      c.addr = 32'h1000_0000 + i;
      c.pfx  = 6'd20;
      c.chk  = (i == 10);
      c.want = ST_FULL;
      send_cmd(c);
    end
    c.func = FUNC_TICK;
    c.chk  = 1'b0;
    send_cmd(c);
    wait_drained();

    // random phases, extremes of the settings first
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: set_config(32'd0, 32'd0, 32'd0, 32'd0, 3'd0);
        1: set_config(32'hFFFF_FFFE, 32'hFFFF_FFFE, 32'hFFFF_FFFE, 32'hFFFF_FFFE, 3'd6);
        2: set_config($urandom_range(0, 20), $urandom, $urandom_range(0, 20),
                      $urandom_range(0, 5), 3'($urandom_range(0, 6)));
        default: set_config($urandom_range(0, 9), $urandom_range(0, 9), $urandom,
                            $urandom_range(0, 9), 3'($urandom_range(0, 6)));
      endcase
      quiet = (ph == 2);
      // the table stays full from the directed part, as no command frees a slot
      for (int n = 0; n < 26; n++) send_cmd(random_cmd());
      wait_drained();
    end

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/dvrt_pkg.sv
hw/rtl/dvrt_front.sv
hw/rtl/dvrt_back.sv
hw/rtl/distance_vector_route_table.sv
verif/distance_vector_route_table_tb.sv
